FILE: sv/mkdr_pkg.sv
package mkdr_pkg;

  localparam int TIMER_W   = 16;
  localparam int CFG_IDX_W = 1;

  typedef logic [TIMER_W-1:0]   timer_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_PRESS  = 2'd1,
    EV_REPEAT = 2'd2
  } ev_kind_t;

  localparam cfg_idx_t CFG_REPEAT_WAIT     = 1'b0;
  localparam cfg_idx_t CFG_REPEAT_INTERVAL = 1'b1;

  localparam timer_t REPEAT_WAIT_RESET     = 16'd100;
  localparam timer_t REPEAT_INTERVAL_RESET = 16'd20;

endpackage

FILE: sv/matrix_keypad_debounce_repeat.sv
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// scan in  | in_valid, in_ready, key_levels            | in
// event out| out_valid, out_ready, event_kind,         | out
//          | key_index, pound_pressed                  |
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// one scan item per cycle sustained while the result is not stalled; the result is registered:
// an input register, then one pass of column encode, compare and timer logic
// into the result register, where the keypad state is also updated.
// rst is synchronous; it clears valids, keypad history, timers and loads the
// register defaults. a stalled result holds both stages; config is always ready.
module matrix_keypad_debounce_repeat #(
  parameter int NUM_COLUMNS = 3,
  parameter int NUM_ROWS    = 4
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [NUM_COLUMNS*NUM_ROWS-1:0]          key_levels,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [1:0]                               event_kind,
  output logic [((NUM_COLUMNS*NUM_ROWS > 1) ?
                 $clog2(NUM_COLUMNS*NUM_ROWS) : 1)-1:0] key_index,
  output logic                                     pound_pressed,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  mkdr_pkg::cfg_idx_t                       cfg_index,
  input  mkdr_pkg::timer_t                         cfg_data
);
  import mkdr_pkg::*;

  localparam int NUM_KEYS = NUM_COLUMNS * NUM_ROWS;
  localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [NUM_ROWS-1:0] col_t;

  localparam key_t POUND_KEY = KEY_W'(NUM_KEYS - 1);

  // configuration
  timer_t repeat_wait_scans;
  timer_t repeat_interval_scans;

  // input register
  logic                in_held;
  logic [NUM_KEYS-1:0] levels;

  // keypad state
  col_t   last_cols [NUM_COLUMNS];
  col_t   held_cols [NUM_COLUMNS];
  logic   repeat_armed;
  key_t   saved_key;
  timer_t wait_timer;
  timer_t interval_timer;

  // next values
  col_t     cur_cols [NUM_COLUMNS];
  col_t     held_cols_next [NUM_COLUMNS];
  logic     repeat_armed_next;
  key_t     saved_key_next;
  timer_t   wait_timer_next;
  timer_t   interval_timer_next;
  ev_kind_t kind_next;
  key_t     key_next;
  logic     pound_next;

  logic   advance;
  logic   qualifies;
  logic   found;
  key_t   rise_key;
  timer_t wait_dec;
  timer_t interval_dec;

  assign advance   = !out_valid || out_ready;
  assign in_ready  = !in_held || advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    // bottom-most pressed row of each column, one-hot by row index
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      cur_cols[c] = '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        if (levels[c*NUM_ROWS + r]) begin
          cur_cols[c] = col_t'(1) << r;
        end
      end
    end

    qualifies = 1'b0;
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      if (cur_cols[c] != '0 && cur_cols[c] == last_cols[c]) begin
        qualifies = 1'b1;
      end
    end

    // first newly pressed key in column-major order
    found    = 1'b0;
    rise_key = '0;
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        if (!found && cur_cols[c][r] && !held_cols[c][r]) begin
          found    = 1'b1;
          rise_key = KEY_W'(c*NUM_ROWS + r);
        end
      end
    end

    wait_dec     = (wait_timer != '0) ? wait_timer - 1'b1 : wait_timer;
    interval_dec = (interval_timer != '0) ? interval_timer - 1'b1 : interval_timer;

    repeat_armed_next   = repeat_armed;
    saved_key_next      = saved_key;
    wait_timer_next     = wait_dec;
    interval_timer_next = interval_dec;
    kind_next           = EV_NONE;
    key_next            = '0;
    pound_next          = 1'b0;

    if (qualifies) begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        held_cols_next[c] = cur_cols[c];
      end
      if (found) begin
        kind_next         = EV_PRESS;
        key_next          = rise_key;
        pound_next        = (rise_key == POUND_KEY);
        saved_key_next    = rise_key;
        repeat_armed_next = 1'b1;
        wait_timer_next   = repeat_wait_scans;
      end else if (repeat_armed && wait_dec == '0 && interval_dec == '0) begin
        kind_next           = EV_REPEAT;
        key_next            = saved_key;
        interval_timer_next = repeat_interval_scans;
      end
    end else begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        held_cols_next[c] = '0;
      end
      repeat_armed_next   = 1'b0;
      interval_timer_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_wait_scans     <= REPEAT_WAIT_RESET;
      repeat_interval_scans <= REPEAT_INTERVAL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REPEAT_WAIT:     repeat_wait_scans     <= cfg_data;
        CFG_REPEAT_INTERVAL: repeat_interval_scans <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
    if (in_ready && in_valid) begin
      levels <= key_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      repeat_armed   <= 1'b0;
      saved_key      <= '0;
      wait_timer     <= '0;
      interval_timer <= '0;
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        last_cols[c] <= '0;
        held_cols[c] <= '0;
      end
    end else if (advance) begin
      out_valid <= in_held;
      if (in_held) begin
        repeat_armed   <= repeat_armed_next;
        saved_key      <= saved_key_next;
        wait_timer     <= wait_timer_next;
        interval_timer <= interval_timer_next;
        for (int c = 0; c < NUM_COLUMNS; c++) begin
          last_cols[c] <= cur_cols[c];
          held_cols[c] <= held_cols_next[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_held) begin
      event_kind    <= kind_next;
      key_index     <= key_next;
      pound_pressed <= pound_next;
    end
  end

endmodule
